// ===== src/mrre_pkg.sv =====
package mrre_pkg;

  // transaction kinds on the input channel
  localparam logic [1:0] REQ_START_CTRL = 2'd0;
  localparam logic [1:0] REQ_START_KS   = 2'd1;
  localparam logic [1:0] REQ_MESSAGE    = 2'd2;
  localparam logic [1:0] REQ_TICK       = 2'd3;

  // result kinds
  localparam logic OUT_SEND = 1'b0;
  localparam logic OUT_DONE = 1'b1;

  // completion status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_PARM = 3'd1;
  localparam logic [2:0] ST_TIMEOUT  = 3'd2;
  localparam logic [2:0] ST_PROTOCOL = 3'd3;
  localparam logic [2:0] ST_DEVICE   = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_REPLY_TIMEOUT = 3'd0;
  localparam logic [2:0] CFG_DEADLINE      = 3'd1;
  localparam logic [2:0] CFG_MAX_SKIPPED   = 3'd2;
  localparam logic [2:0] CFG_CTRL_EP       = 3'd3;
  localparam logic [2:0] CFG_KS_EP         = 3'd4;
  localparam logic [2:0] CFG_DMA_ALIGN     = 3'd5;
  localparam logic [2:0] CFG_DMA_BITS      = 3'd6;

  // reset values of the configuration registers
  localparam logic [31:0] RST_REPLY_TIMEOUT = 32'd500000;
  localparam logic [31:0] RST_DEADLINE      = 32'd5000000;
  localparam logic [7:0]  RST_MAX_SKIPPED   = 8'd16;
  localparam logic [7:0]  RST_CTRL_EP       = 8'd0;
  localparam logic [7:0]  RST_KS_EP         = 8'd7;
  localparam logic [4:0]  RST_DMA_ALIGN     = 5'd12;
  localparam logic [6:0]  RST_DMA_BITS      = 7'd44;

  typedef struct packed {
    logic [31:0] reply_timeout_ticks;
    logic [31:0] deadline_ticks;
    logic [7:0]  max_skipped;
    logic [7:0]  control_endpoint;
    logic [7:0]  keyservice_endpoint;
    logic [4:0]  dma_align_log2;
    logic [6:0]  dma_addr_bits;
  } cfg_t;

  // checked and packed start request
  typedef struct packed {
    logic        bad;
    logic        keyservice;
    logic [7:0]  match_tag;
    logic [7:0]  match_trans;
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
  } pack_t;

endpackage

// ===== src/mrre_pack.sv =====
module mrre_pack import mrre_pkg::*; (
  input  logic        keyservice,
  input  logic [7:0]  opcode,
  input  logic [7:0]  tag,
  input  logic [7:0]  operation,
  input  logic [7:0]  transaction_id,
  input  logic [63:0] dma_address,
  input  logic [32:0] size_bytes,
  input  logic [16:0] request_length,
  input  cfg_t        cfg,
  output pack_t       pack
);

  logic [63:0] align_mask;
  logic        misaligned;
  logic        too_wide;

  assign align_mask = (64'd1 << cfg.dma_align_log2) - 64'd1;
  assign misaligned = (dma_address & align_mask) != 64'd0;
  assign too_wide   = (cfg.dma_addr_bits < 7'd64) &&
                      ((dma_address >> cfg.dma_addr_bits) != 64'd0);

  always_comb begin
    if (keyservice) begin
      pack.bad         = request_length[16];
      pack.keyservice  = 1'b1;
      pack.match_tag   = {1'b0, operation[6:0]};
      pack.match_trans = transaction_id;
      pack.word0       = {8'h00, transaction_id, operation, cfg.keyservice_endpoint};
      pack.word1       = {request_length[15:0], 16'h0000};
      pack.word2       = 32'd0;
    end else begin
      pack.bad         = misaligned || too_wide || size_bytes[32];
      pack.keyservice  = 1'b0;
      pack.match_tag   = tag;
      pack.match_trans = 8'd0;
      pack.word0       = {cfg.keyservice_endpoint, opcode, tag, cfg.control_endpoint};
      pack.word1       = dma_address[43:12];
      pack.word2       = size_bytes[31:0];
    end
  end

endmodule

// ===== src/mailbox_request_reply_engine.sv =====
// a transaction held in the input register is processed once the output slot is free, and any result is registered
// throughput: one input transaction per cycle while not stalled, set by the single input and result registers
// the input side stalls only while a result is held and the output side stalls
// reset (rst, synchronous, active high) returns to idle, clears counters and match state,
// and loads the configuration registers with their documented defaults
module mailbox_request_reply_engine import mrre_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_write_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [7:0]  opcode,
  input  logic [7:0]  tag,
  input  logic [7:0]  operation,
  input  logic [7:0]  transaction_id,
  input  logic [63:0] dma_address,
  input  logic [32:0] size_bytes,
  input  logic [16:0] request_length,
  input  logic [31:0] reply_word0,
  input  logic [31:0] reply_word1,
  input  logic        outbox_busy,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [31:0] send_word0,
  output logic [31:0] send_word1,
  output logic [31:0] send_word2,
  output logic [2:0]  status,
  output logic        sent_to_device,
  output logic [15:0] reply_length
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_OUTBOX,
    PH_REPLY
  } phase_t;

  // configuration registers
  cfg_t cfg;

  // input register stage
  logic        s1_valid;
  logic [1:0]  s1_req_type;
  logic [7:0]  s1_opcode;
  logic [7:0]  s1_tag;
  logic [7:0]  s1_operation;
  logic [7:0]  s1_trans;
  logic [63:0] s1_dma;
  logic [32:0] s1_size;
  logic [16:0] s1_reqlen;
  logic [31:0] s1_w0;
  logic [31:0] s1_w1;
  logic        s1_full;

  // engine state
  phase_t      phase, phase_next;
  logic        keyservice_mode, keyservice_mode_next;
  logic [31:0] pending_words [3];
  logic [31:0] pending_words_next [3];
  logic [7:0]  match_tag, match_tag_next;
  logic [7:0]  match_trans, match_trans_next;
  logic [31:0] deadline_elapsed, deadline_elapsed_next;
  logic [31:0] wait_elapsed, wait_elapsed_next;
  logic [7:0]  skipped_count, skipped_count_next;

  // result of the current transaction
  logic        res_valid;
  logic        res_kind;
  logic [31:0] res_w0, res_w1, res_w2;
  logic [2:0]  res_status;
  logic        res_sent;
  logic [15:0] res_len;

  logic        slot_free;
  logic        proc;
  pack_t       pk;

  // effective limits, zero acts as one
  logic [31:0] timeout_eff;
  logic [31:0] deadline_eff;
  logic [7:0]  skip_eff;
  logic [31:0] wait_inc;
  logic [31:0] deadline_inc;
  logic [7:0]  skip_inc;
  logic        msg_hit;

  // the output register is free when empty or being drained this cycle
  assign slot_free = !out_valid || !out_stall;
  assign proc      = s1_valid && slot_free;
  assign in_stall  = s1_valid && !slot_free;

  assign timeout_eff  = (cfg.reply_timeout_ticks == 32'd0) ? 32'd1 : cfg.reply_timeout_ticks;
  assign deadline_eff = (cfg.deadline_ticks == 32'd0) ? 32'd1 : cfg.deadline_ticks;
  assign skip_eff     = (cfg.max_skipped == 8'd0) ? 8'd1 : cfg.max_skipped;
  assign wait_inc     = wait_elapsed + 32'd1;
  assign deadline_inc = deadline_elapsed + 32'd1;
  assign skip_inc     = skipped_count + 8'd1;

  // reply matching: endpoint plus tag, or endpoint plus 7-bit operation plus transaction
  always_comb begin
    if (keyservice_mode) begin
      msg_hit = (s1_w0[7:0] == cfg.keyservice_endpoint) &&
                ({1'b0, s1_w0[14:8]} == match_tag) &&
                (s1_w0[23:16] == match_trans);
    end else begin
      msg_hit = (s1_w0[7:0] == cfg.control_endpoint) && (s1_w0[15:8] == match_tag);
    end
  end

  mrre_pack u_pack (
    .keyservice     (s1_req_type == REQ_START_KS),
    .opcode         (s1_opcode),
    .tag            (s1_tag),
    .operation      (s1_operation),
    .transaction_id (s1_trans),
    .dma_address    (s1_dma),
    .size_bytes     (s1_size),
    .request_length (s1_reqlen),
    .cfg            (cfg),
    .pack           (pk)
  );

  // event handling for the transaction held in the input register
  always_comb begin
    phase_next            = phase;
    keyservice_mode_next  = keyservice_mode;
    pending_words_next    = pending_words;
    match_tag_next        = match_tag;
    match_trans_next      = match_trans;
    deadline_elapsed_next = deadline_elapsed;
    wait_elapsed_next     = wait_elapsed;
    skipped_count_next    = skipped_count;
    res_valid  = 1'b0;
    res_kind   = OUT_SEND;
    res_w0     = 32'd0;
    res_w1     = 32'd0;
    res_w2     = 32'd0;
    res_status = ST_OK;
    res_sent   = 1'b0;
    res_len    = 16'd0;
    if (proc) begin
      case (s1_req_type)
        REQ_START_CTRL, REQ_START_KS: begin
          // starts while busy are dropped
          if (phase == PH_IDLE) begin
            if (pk.bad) begin
              res_valid  = 1'b1;
              res_kind   = OUT_DONE;
              res_status = ST_BAD_PARM;
            end else begin
              keyservice_mode_next  = pk.keyservice;
              match_tag_next        = pk.match_tag;
              match_trans_next      = pk.match_trans;
              pending_words_next[0] = pk.word0;
              pending_words_next[1] = pk.word1;
              pending_words_next[2] = pk.word2;
              if (!s1_full) begin
                // outbox free, send right away
                res_valid             = 1'b1;
                res_kind              = OUT_SEND;
                res_w0                = pk.word0;
                res_w1                = pk.word1;
                res_w2                = pk.word2;
                phase_next            = PH_REPLY;
                deadline_elapsed_next = 32'd0;
                wait_elapsed_next     = 32'd0;
                skipped_count_next    = 8'd0;
              end else begin
                phase_next        = PH_OUTBOX;
                wait_elapsed_next = 32'd0;
              end
            end
          end
        end
        REQ_TICK: begin
          if (phase == PH_OUTBOX) begin
            wait_elapsed_next = wait_inc;
            if (wait_inc >= timeout_eff) begin
              res_valid  = 1'b1;
              res_kind   = OUT_DONE;
              res_status = ST_TIMEOUT;
              phase_next = PH_IDLE;
            end else if (!s1_full) begin
              res_valid             = 1'b1;
              res_kind              = OUT_SEND;
              res_w0                = pending_words[0];
              res_w1                = pending_words[1];
              res_w2                = pending_words[2];
              phase_next            = PH_REPLY;
              deadline_elapsed_next = 32'd0;
              wait_elapsed_next     = 32'd0;
              skipped_count_next    = 8'd0;
            end
          end else if (phase == PH_REPLY) begin
            wait_elapsed_next     = wait_inc;
            deadline_elapsed_next = deadline_inc;
            if ((wait_inc >= timeout_eff) || (deadline_inc >= deadline_eff)) begin
              res_valid  = 1'b1;
              res_kind   = OUT_DONE;
              res_status = ST_TIMEOUT;
              res_sent   = 1'b1;
              phase_next = PH_IDLE;
            end
          end
        end
        REQ_MESSAGE: begin
          // messages only count while a reply is awaited
          if (phase == PH_REPLY) begin
            if (msg_hit) begin
              res_valid  = 1'b1;
              res_kind   = OUT_DONE;
              res_sent   = 1'b1;
              phase_next = PH_IDLE;
              if (keyservice_mode) begin
                res_len = s1_w1[31:16];
              end else begin
                res_status = (s1_w1 != 32'd0) ? ST_DEVICE : ST_OK;
              end
            end else begin
              // unrelated message
              wait_elapsed_next  = 32'd0;
              skipped_count_next = skip_inc;
              if (skip_inc >= skip_eff) begin
                res_valid  = 1'b1;
                res_kind   = OUT_DONE;
                res_status = ST_PROTOCOL;
                res_sent   = 1'b1;
                phase_next = PH_IDLE;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reply_timeout_ticks <= RST_REPLY_TIMEOUT;
      cfg.deadline_ticks      <= RST_DEADLINE;
      cfg.max_skipped         <= RST_MAX_SKIPPED;
      cfg.control_endpoint    <= RST_CTRL_EP;
      cfg.keyservice_endpoint <= RST_KS_EP;
      cfg.dma_align_log2      <= RST_DMA_ALIGN;
      cfg.dma_addr_bits       <= RST_DMA_BITS;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_REPLY_TIMEOUT: cfg.reply_timeout_ticks <= cfg_data;
        CFG_DEADLINE:      cfg.deadline_ticks      <= cfg_data;
        CFG_MAX_SKIPPED:   cfg.max_skipped         <= cfg_data[7:0];
        CFG_CTRL_EP:       cfg.control_endpoint    <= cfg_data[7:0];
        CFG_KS_EP:         cfg.keyservice_endpoint <= cfg_data[7:0];
        CFG_DMA_ALIGN:     cfg.dma_align_log2      <= cfg_data[4:0];
        CFG_DMA_BITS:      cfg.dma_addr_bits       <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (proc) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_req_type  <= req_type;
      s1_opcode    <= opcode;
      s1_tag       <= tag;
      s1_operation <= operation;
      s1_trans     <= transaction_id;
      s1_dma       <= dma_address;
      s1_size      <= size_bytes;
      s1_reqlen    <= request_length;
      s1_w0        <= reply_word0;
      s1_w1        <= reply_word1;
      s1_full      <= outbox_busy;
    end
  end

  // engine state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      keyservice_mode  <= 1'b0;
      match_tag        <= 8'd0;
      match_trans      <= 8'd0;
      deadline_elapsed <= 32'd0;
      wait_elapsed     <= 32'd0;
      skipped_count    <= 8'd0;
    end else begin
      phase            <= phase_next;
      keyservice_mode  <= keyservice_mode_next;
      match_tag        <= match_tag_next;
      match_trans      <= match_trans_next;
      deadline_elapsed <= deadline_elapsed_next;
      wait_elapsed     <= wait_elapsed_next;
      skipped_count    <= skipped_count_next;
    end
  end

  // pending request words, meaningful only once a start has packed them
  always_ff @(posedge clk) begin
    pending_words <= pending_words_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= proc && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && res_valid) begin
      out_kind       <= res_kind;
      send_word0     <= res_w0;
      send_word1     <= res_w1;
      send_word2     <= res_w2;
      status         <= res_status;
      sent_to_device <= res_sent;
      reply_length   <= res_len;
    end
  end

`ifndef ASSERT_OFF
  // a send result always leaves the engine waiting for the reply
  a_send_to_reply: assert property (@(posedge clk) disable iff (rst)
    (proc && res_valid && (res_kind == OUT_SEND)) |=> (phase == PH_REPLY))
    else $error("send result did not enter reply wait");

  // a completion always returns the engine to idle
  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    (proc && res_valid && (res_kind == OUT_DONE)) |=> (phase == PH_IDLE))
    else $error("completion did not return to idle");

  // the input side only stalls while a held result blocks the input register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // a send is only produced from idle or outbox wait
  a_send_origin: assert property (@(posedge clk) disable iff (rst)
    (proc && res_valid && (res_kind == OUT_SEND)) |-> (phase != PH_REPLY))
    else $error("send produced during reply wait");
`endif

endmodule

// ===== verif/mailbox_request_reply_engine_test.sv =====
`timescale 1ns / 1ps

module mailbox_request_reply_engine_test;
  import mrre_pkg::*;

  localparam int PHASE_ITEMS = 68;   // random input transactions per phase
  localparam int HOLD_CYCLES = 60;   // long receiver hold-off under pressure
  localparam int STUCK_LIMIT = 2000; // cycles with no transaction before giving up
  localparam int SETTLE_CYCLES = 4;  // margin after the last owed result, before settings change

  // one input transaction, all payload fields
  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  opcode;
    logic [7:0]  tag;
    logic [7:0]  operation;
    logic [7:0]  transaction_id;
    logic [63:0] dma_address;
    logic [32:0] size_bytes;
    logic [16:0] request_length;
    logic [31:0] reply_word0;
    logic [31:0] reply_word1;
    logic        outbox_busy;
  } mb_item_t;

  // one output transaction: a word send or a completion
  typedef struct packed {
    logic        kind;
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
    logic [2:0]  status;
    logic        sent;
    logic [15:0] length;
  } mb_result_t;

  // engine phases as the model of the engine tracks them
  typedef enum logic [1:0] {ENG_IDLE, ENG_DRAIN, ENG_AWAIT} eng_phase_t;

  // clock, reset and every block input start at known values
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type = '0;
  logic [7:0]  opcode = '0;
  logic [7:0]  tag = '0;
  logic [7:0]  operation = '0;
  logic [7:0]  transaction_id = '0;
  logic [63:0] dma_address = '0;
  logic [32:0] size_bytes = '0;
  logic [16:0] request_length = '0;
  logic [31:0] reply_word0 = '0;
  logic [31:0] reply_word1 = '0;
  logic        outbox_busy = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic [31:0] send_word0;
  logic [31:0] send_word1;
  logic [31:0] send_word2;
  logic [2:0]  status;
  logic        sent_to_device;
  logic [15:0] reply_length;

  mailbox_request_reply_engine dut (.*);

  initial forever #2 clk = ~clk;

  // stimulus side bookkeeping
  mb_item_t   request_q[$];      // input transactions waiting for the driver
  mb_item_t   offered;           // transaction currently on the input port
  int         requests_open = 0; // queued or offered, not yet accepted
  int         queued_total = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         holds_wanted = 0;
  int         holds_begun = 0;
  int         hold_left = 0;
  int         mismatches = 0;

  // engine model: configuration copy, state, and the outputs it owes
  cfg_t        cfg_model;
  eng_phase_t  eng_phase;
  logic        ks_mode;
  logic [31:0] held_words[3];
  logic [7:0]  want_tag;
  logic [7:0]  want_trans;
  logic [31:0] deadline_count;
  logic [31:0] wait_count;
  logic [7:0]  skip_count;
  mb_result_t  mailbox_out_q[$];

  // words go out, reply wait starts with fresh counters
  function automatic void post_send();
    mailbox_out_q.push_back('{OUT_SEND, held_words[0], held_words[1], held_words[2],
                              ST_OK, 1'b0, 16'd0});
    eng_phase = ENG_AWAIT;
    deadline_count = '0;
    wait_count = '0;
    skip_count = '0;
  endfunction

  function automatic void post_done(logic [2:0] st, logic sent, logic [15:0] len);
    mailbox_out_q.push_back('{OUT_DONE, 32'd0, 32'd0, 32'd0, st, sent, len});
    eng_phase = ENG_IDLE;
  endfunction

  // send right away when the outbox has room, else wait for it to drain
  function automatic void launch_request(logic full);
    if (!full) begin
      post_send();
    end else begin
      eng_phase = ENG_DRAIN;
      wait_count = '0;
    end
  endfunction

  function automatic void step_mailbox_engine(mb_item_t it);
    logic [63:0] align_mask;
    logic [31:0] wait_lim;
    logic [31:0] dl_lim;
    logic [7:0]  skip_lim;
    logic        hit;
    // a limit of zero behaves as one
    wait_lim = (cfg_model.reply_timeout_ticks == 0) ? 32'd1 : cfg_model.reply_timeout_ticks;
    dl_lim = (cfg_model.deadline_ticks == 0) ? 32'd1 : cfg_model.deadline_ticks;
    skip_lim = (cfg_model.max_skipped == 0) ? 8'd1 : cfg_model.max_skipped;
    align_mask = (64'd1 << cfg_model.dma_align_log2) - 64'd1;
    case (it.req_type)
      REQ_START_CTRL: begin
        if (eng_phase == ENG_IDLE) begin
          if ((it.dma_address & align_mask) != 0 ||
              (cfg_model.dma_addr_bits < 7'd64 &&
               (it.dma_address >> cfg_model.dma_addr_bits) != 0) ||
              it.size_bytes[32]) begin
            post_done(ST_BAD_PARM, 1'b0, 16'd0);
          end else begin
            ks_mode = 1'b0;
            want_tag = it.tag;
            want_trans = '0;
            held_words[0] = {cfg_model.keyservice_endpoint, it.opcode, it.tag,
                             cfg_model.control_endpoint};
            held_words[1] = it.dma_address[43:12];
            held_words[2] = it.size_bytes[31:0];
            launch_request(it.outbox_busy);
          end
        end
      end
      REQ_START_KS: begin
        if (eng_phase == ENG_IDLE) begin
          if (it.request_length[16]) begin
            post_done(ST_BAD_PARM, 1'b0, 16'd0);
          end else begin
            ks_mode = 1'b1;
            want_tag = {1'b0, it.operation[6:0]};
            want_trans = it.transaction_id;
            held_words[0] = {8'd0, it.transaction_id, it.operation,
                             cfg_model.keyservice_endpoint};
            held_words[1] = {it.request_length[15:0], 16'd0};
            held_words[2] = '0;
            launch_request(it.outbox_busy);
          end
        end
      end
      REQ_TICK: begin
        if (eng_phase == ENG_DRAIN) begin
          wait_count = wait_count + 32'd1;
          if (wait_count >= wait_lim) post_done(ST_TIMEOUT, 1'b0, 16'd0);
          else if (!it.outbox_busy) post_send();
        end else if (eng_phase == ENG_AWAIT) begin
          wait_count = wait_count + 32'd1;
          deadline_count = deadline_count + 32'd1;
          if (wait_count >= wait_lim || deadline_count >= dl_lim)
            post_done(ST_TIMEOUT, 1'b1, 16'd0);
        end
      end
      REQ_MESSAGE: begin
        if (eng_phase == ENG_AWAIT) begin
          // key service matches only the low 7 bits of the operation
          if (ks_mode)
            hit = it.reply_word0[7:0] == cfg_model.keyservice_endpoint &&
                  it.reply_word0[14:8] == want_tag[6:0] &&
                  it.reply_word0[23:16] == want_trans;
          else
            hit = it.reply_word0[7:0] == cfg_model.control_endpoint &&
                  it.reply_word0[15:8] == want_tag;
          if (hit) begin
            if (ks_mode) post_done(ST_OK, 1'b1, it.reply_word1[31:16]);
            else post_done((it.reply_word1 != 0) ? ST_DEVICE : ST_OK, 1'b1, 16'd0);
          end else begin
            // unrelated message restarts the per-message wait
            wait_count = '0;
            skip_count = skip_count + 8'd1;
            if (skip_count >= skip_lim) post_done(ST_PROTOCOL, 1'b1, 16'd0);
          end
        end
      end
    endcase
  endfunction

  // driver: a new transaction goes up only once the last one was taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        step_mailbox_engine(offered);
        requests_open--;
      end
      if (!in_valid || !in_stall) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = request_q.pop_front();
          req_type <= offered.req_type;
          opcode <= offered.opcode;
          tag <= offered.tag;
          operation <= offered.operation;
          transaction_id <= offered.transaction_id;
          dma_address <= offered.dma_address;
          size_bytes <= offered.size_bytes;
          request_length <= offered.request_length;
          reply_word0 <= offered.reply_word0;
          reply_word1 <= offered.reply_word1;
          outbox_busy <= offered.outbox_busy;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off when one is requested
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (holds_begun != holds_wanted) begin
      holds_begun++;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // monitor: every accepted result against the oldest owed one
  always @(posedge clk) begin : monitor
    mb_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (mailbox_out_q.size() == 0) begin
        $error("out_kind: expected no transaction, got %0d", out_kind);
        mismatches++;
      end else begin
        want = mailbox_out_q.pop_front();
        check_field("out_kind", 32'(want.kind), 32'(out_kind));
        check_field("send_word0", want.word0, send_word0);
        check_field("send_word1", want.word1, send_word1);
        check_field("send_word2", want.word2, send_word2);
        check_field("status", 32'(want.status), 32'(status));
        check_field("sent_to_device", 32'(want.sent), 32'(sent_to_device));
        check_field("reply_length", 32'(want.length), 32'(reply_length));
      end
    end
  end

  // watchdog on cycles where neither side completes a transaction
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  function automatic mb_item_t random_item();
    mb_item_t it;
    it.req_type = 2'($urandom_range(3));
    it.opcode = 8'($urandom);
    it.tag = 8'($urandom);
    it.operation = 8'($urandom);
    it.transaction_id = 8'($urandom);
    it.dma_address = {$urandom, $urandom};
    it.size_bytes = {1'($urandom_range(1)), $urandom};
    it.request_length = 17'($urandom);
    it.reply_word0 = $urandom;
    it.reply_word1 = $urandom;
    it.outbox_busy = 1'($urandom_range(1));
    return it;
  endfunction

  task automatic push_item(input mb_item_t it);
    request_q.push_back(it);
    requests_open++;
    queued_total++;
  endtask

  // builders: unused fields carry random junk
  task automatic send_ctrl(input logic [7:0] op, tg, input logic [63:0] dma,
                           input logic [32:0] size, input logic full);
    mb_item_t it;
    it = random_item();
    it.req_type = REQ_START_CTRL;
    it.opcode = op;
    it.tag = tg;
    it.dma_address = dma;
    it.size_bytes = size;
    it.outbox_busy = full;
    push_item(it);
  endtask

  task automatic send_ks(input logic [7:0] op, trans, input logic [16:0] len,
                         input logic full);
    mb_item_t it;
    it = random_item();
    it.req_type = REQ_START_KS;
    it.operation = op;
    it.transaction_id = trans;
    it.request_length = len;
    it.outbox_busy = full;
    push_item(it);
  endtask

  task automatic send_inbox(input logic [31:0] w0, w1);
    mb_item_t it;
    it = random_item();
    it.req_type = REQ_MESSAGE;
    it.reply_word0 = w0;
    it.reply_word1 = w1;
    push_item(it);
  endtask

  task automatic send_tick(input logic full);
    mb_item_t it;
    it = random_item();
    it.req_type = REQ_TICK;
    it.outbox_busy = full;
    push_item(it);
  endtask

  // one request/reply exchange: start, optional drain, noise, then the reply or silence
  task automatic queue_exchange();
    logic        ks;
    logic        full;
    logic [7:0]  op;
    logic [7:0]  tg;
    logic [7:0]  trans;
    logic [63:0] dma;
    logic [32:0] size;
    logic [16:0] len;
    logic [31:0] w0;
    logic [31:0] w1;
    logic        short_wait;
    int          n;
    ks = 1'($urandom_range(1));
    full = ($urandom_range(3) == 0);
    op = 8'($urandom);
    tg = 8'($urandom);
    trans = 8'($urandom);
    short_wait = (cfg_model.reply_timeout_ticks <= 8);
    if (ks) begin
      len = 17'($urandom);
      len[16] = ($urandom_range(9) == 0);
      send_ks(op, trans, len, full);
    end else begin
      // legal address for the current alignment and width, then maybe break it
      dma = {$urandom, $urandom};
      dma &= ~((64'd1 << cfg_model.dma_align_log2) - 64'd1);
      if (cfg_model.dma_addr_bits < 7'd64)
        dma &= (64'd1 << cfg_model.dma_addr_bits) - 64'd1;
      size = {1'b0, $urandom};
      case ($urandom_range(11))
        0: if (cfg_model.dma_align_log2 != 0)
             dma[$urandom_range(cfg_model.dma_align_log2 - 1)] = 1'b1;
        1: if (cfg_model.dma_addr_bits < 7'd64)
             dma[$urandom_range(63, cfg_model.dma_addr_bits)] = 1'b1;
        2: size[32] = 1'b1;
        default: ;
      endcase
      send_ctrl(op, tg, dma, size, full);
    end
    // outbox busy for a while; a long timeout must not leave it stuck
    if (full) begin
      n = $urandom_range(4);
      repeat (n) send_tick(1'b1);
      send_tick(short_wait && $urandom_range(3) == 0);
    end
    // ticks and unrelated messages, some of them near misses
    n = $urandom_range(4);
    repeat (n) begin
      if ($urandom_range(1)) begin
        send_tick(1'($urandom_range(1)));
      end else begin
        w0 = $urandom;
        if ($urandom_range(1)) begin
          if (ks) w0[23:0] = {trans + 8'd1, w0[15], op[6:0], cfg_model.keyservice_endpoint};
          else w0[15:0] = {tg + 8'd1, cfg_model.control_endpoint};
        end
        send_inbox(w0, $urandom);
      end
    end
    // the matching reply, or silence when a timeout can end the wait
    if ($urandom_range(9) != 0 || !short_wait) begin
      w0 = $urandom;
      if (ks) w0[23:0] = {trans, w0[15], op[6:0], cfg_model.keyservice_endpoint};
      else w0[15:0] = {tg, cfg_model.control_endpoint};
      w1 = $urandom;
      if (!ks && $urandom_range(1)) w1 = '0;
      send_inbox(w0, w1);
    end else begin
      repeat (8) send_tick(1'($urandom_range(1)));
    end
  endtask

  // wait until every transaction is in and every owed result is out
  task automatic settle_engine();
    do @(negedge clk); while (requests_open != 0 || mailbox_out_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_REPLY_TIMEOUT: cfg_model.reply_timeout_ticks = val;
      CFG_DEADLINE:      cfg_model.deadline_ticks = val;
      CFG_MAX_SKIPPED:   cfg_model.max_skipped = val[7:0];
      CFG_CTRL_EP:       cfg_model.control_endpoint = val[7:0];
      CFG_KS_EP:         cfg_model.keyservice_endpoint = val[7:0];
      CFG_DMA_ALIGN:     cfg_model.dma_align_log2 = val[4:0];
      CFG_DMA_BITS:      cfg_model.dma_addr_bits = val[6:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic apply_settings(input logic [31:0] timeout, deadline, skips,
                                ctrl_ep, ks_ep, align, bits);
    settle_engine();
    write_reg(CFG_REPLY_TIMEOUT, timeout);
    write_reg(CFG_DEADLINE, deadline);
    write_reg(CFG_MAX_SKIPPED, skips);
    write_reg(CFG_CTRL_EP, ctrl_ep);
    write_reg(CFG_KS_EP, ks_ep);
    write_reg(CFG_DMA_ALIGN, align);
    write_reg(CFG_DMA_BITS, bits);
  endtask

  task automatic run_random_phase(input int send_pct, recv_pct, input bit hold);
    int goal;
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    if (hold) holds_wanted++;
    goal = queued_total + PHASE_ITEMS;
    while (queued_total < goal) begin
      if ($urandom_range(9) == 0) push_item(random_item());
      else queue_exchange();
    end
  endtask

  initial begin
    // model starts where the block comes out of reset
    cfg_model = '{RST_REPLY_TIMEOUT, RST_DEADLINE, RST_MAX_SKIPPED, RST_CTRL_EP,
                  RST_KS_EP, RST_DMA_ALIGN, RST_DMA_BITS};
    eng_phase = ENG_IDLE;
    ks_mode = 1'b0;
    held_words = '{default: '0};
    want_tag = '0;
    want_trans = '0;
    deadline_count = '0;
    wait_count = '0;
    skip_count = '0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, default settings
    send_tick(1'b0);                                    // tick while idle
    send_inbox(32'h0000_ff00, 32'h0);                   // message while idle
    send_ctrl(8'hff, 8'hff, 64'h0000_0fff_ffff_f000, 33'h0_ffff_ffff, 1'b0);
    send_ks(8'h00, 8'h00, 17'd0, 1'b0);                 // start while busy
    send_inbox(32'hffff_fe00, 32'hffff_ffff);           // wrong tag
    send_inbox(32'hffff_ff00, 32'h0);                   // match, ok
    send_ctrl(8'h00, 8'h00, 64'd0, 33'd0, 1'b1);        // outbox full
    send_inbox(32'h0, 32'h0);                           // ignored while draining
    send_tick(1'b1);
    send_tick(1'b0);                                    // outbox drained, words go out
    send_inbox(32'h0000_0000, 32'h8000_0000);           // device error
    send_ctrl(8'h12, 8'h34, 64'h800, 33'd16, 1'b0);     // misaligned
    send_ctrl(8'h12, 8'h34, 64'h0000_1000_0000_0000, 33'd16, 1'b0); // address too wide
    send_ctrl(8'h12, 8'h34, 64'h1000, 33'h1_0000_0000, 1'b0);        // size too big
    send_ks(8'h55, 8'h66, 17'h1_0000, 1'b0);            // length too big
    send_ks(8'hff, 8'hff, 17'h0_ffff, 1'b0);
    send_inbox(32'h00fe_7f07, 32'h0);                   // wrong transaction
    send_inbox(32'h00ff_7f07, 32'hffff_0000);           // operation bit 7 not compared

    // directed, short timeouts: drain timeout, then reply deadline
    apply_settings(32'd2, 32'd3, 32'd3, 32'h00, 32'h07, 32'd12, 32'd44);
    @(negedge clk);
    send_ctrl(8'h01, 8'h02, 64'h3000, 33'd1, 1'b1);
    send_tick(1'b1);
    send_tick(1'b1);
    send_ks(8'h01, 8'h02, 17'd3, 1'b0);
    send_tick(1'b0);
    send_inbox(32'h0, 32'h0);
    send_tick(1'b0);
    send_inbox(32'h0, 32'h0);
    send_tick(1'b0);

    // random phases across settings, extremes first, with every idling mix
    apply_settings(32'd3, 32'd10, 32'd2, 32'h5a, 32'hff, 32'd0, 32'd64);
    run_random_phase(0, 0, 1'b1);
    apply_settings(32'd1, 32'd1, 32'd1, 32'hff, 32'h00, 32'd16, 32'd12);
    run_random_phase(47, 0, 1'b0);
    apply_settings(32'hffff_ffff, 32'hffff_ffff, 32'd255, $urandom_range(255),
                   $urandom_range(255), 32'd5, 32'd40);
    run_random_phase(0, 47, 1'b0);
    // zero limits, out-of-range alignment and width
    apply_settings(32'd0, 32'd0, 32'd0, $urandom_range(255), $urandom_range(255),
                   32'd31, 32'd127);
    run_random_phase(20, 20, 1'b0);
    apply_settings($urandom_range(10, 1), $urandom_range(30, 1), $urandom_range(6, 1),
                   $urandom_range(255), $urandom_range(255), $urandom_range(16),
                   $urandom_range(64, 12));
    run_random_phase(20, 20, 1'b0);
    apply_settings($urandom_range(10, 1), $urandom_range(30, 1), $urandom_range(6, 1),
                   $urandom_range(255), $urandom_range(255), $urandom_range(16),
                   $urandom_range(64, 12));
    run_random_phase(0, 0, 1'b0);
    apply_settings($urandom_range(10, 1), $urandom_range(30, 1), $urandom_range(6, 1),
                   $urandom_range(255), $urandom_range(255), $urandom_range(16),
                   $urandom_range(64, 12));
    run_random_phase(47, 0, 1'b0);

    settle_engine();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
